/* design/linear_probe_hash_table_top_defines.svh */
// Assertion macros shared by the checker of the hash table block.
// Depends on nothing; each macro expects clk and rst_n in the using scope.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lpht_pkg.sv */
// Shared types and constants of the linear probing hash table.
// Used by the controller, the datapath, the top level and the checker.
package lpht_pkg;

  localparam int SLOTS_DEF = 11;
  localparam int KEY_W     = 12;
  localparam int CHAR_W    = 8;
  localparam int SLOT_W    = 6;
  localparam int PROBE_W   = 7;
  localparam logic [KEY_W-1:0] KEY_MAX = 12'hFFF;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_INIT,
    S_RD,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic acc_char;
    logic start_key;
    logic mod_step;
    logic probe_init;
    logic mem_rd;
    logic probe_eval;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic probe_hit;
    logic probe_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/lpht_ctrl.sv */
// Controller state machine of the hash table: sequences the key reduction,
// the probe walk and the result hand-off. Depends on lpht_pkg.
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_char,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_last_char) begin
            cmd.start_key = 1'b1;
            state_nxt     = S_MOD;
          end else begin
            cmd.acc_char = 1'b1;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.probe_init = 1'b1;
        state_nxt      = S_RD;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.probe_eval = 1'b1;
        if (stat.probe_hit || stat.probe_last) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* design/lpht_dp.sv */
// Datapath of the hash table: key accumulator, reciprocal modulo unit,
// slot key memory with valid bits, probe counters and result register.
// Depends on lpht_pkg.
module lpht_dp
  import lpht_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic                in_mode,
  input  logic [CHAR_W-1:0]   in_char_code,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [PROBE_W-1:0]  out_probes,
  output logic [KEY_W-1:0]    out_key
);

  localparam int IW = $clog2(SLOTS);
  localparam int RW = $clog2(2 * SLOTS);
  localparam int RECIP_SH = 24;
  localparam int PROD_W   = KEY_W + RECIP_SH;
  localparam logic [RW-1:0] SLOTS_R  = RW'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [KEY_W-1:0] SLOTS_K = KEY_W'(SLOTS);
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((1 << RECIP_SH) / SLOTS);

  logic [KEY_W-1:0]   sum_r;
  logic [KEY_W:0]     sum_ext;
  logic [KEY_W-1:0]   sum_sat;
  logic [KEY_W-1:0]   key_r;
  logic               mode_r;
  logic               mphase_r;
  logic [PROD_W-1:0]  recip_prod;
  logic [KEY_W-1:0]   quot_r;
  logic [KEY_W-1:0]   rem_full;
  logic [RW-1:0]      rem_r;
  logic [RW-1:0]      home_slot;
  logic [IW-1:0]      pos_r;
  logic [IW-1:0]      pos_inc;
  logic [IW-1:0]      cnt_r;
  logic [KEY_W-1:0]   mem [SLOTS];
  logic [KEY_W-1:0]   mem_q;
  logic [SLOTS-1:0]   valid_r;
  logic               valid_q;
  logic [KEY_W-1:0]   eff_key;
  logic               hit;
  logic               last_probe;
  status_t            res_status_r;
  logic [SLOT_W-1:0]  res_slot_r;
  logic [PROBE_W-1:0] res_probes_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [PROBE_W-1:0] out_probes_r;
  logic [KEY_W-1:0]   out_key_r;

  assign sum_ext = {1'b0, sum_r} + {{(KEY_W + 1 - CHAR_W){1'b0}}, in_char_code};
  assign sum_sat = sum_ext[KEY_W] ? KEY_MAX : sum_ext[KEY_W-1:0];

  // The quotient estimate is low by at most one, so one subtraction finishes the remainder.
  assign recip_prod = {{RECIP_SH{1'b0}}, key_r} * {{KEY_W{1'b0}}, RECIP};
  assign rem_full   = key_r - quot_r * SLOTS_K;
  assign home_slot  = (rem_r >= SLOTS_R) ? (rem_r - SLOTS_R) : rem_r;

  assign pos_inc    = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
  assign eff_key    = valid_q ? mem_q : '0;
  assign hit        = (mode_r == MODE_INSERT) ? (eff_key == '0) : (eff_key == key_r);
  assign last_probe = (cnt_r == LAST_IDX);

  assign stat.mod_done   = mphase_r;
  assign stat.probe_hit  = hit;
  assign stat.probe_last = last_probe;
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.acc_char) begin
      sum_r <= sum_sat;
    end else if (cmd.start_key) begin
      sum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_key) begin
      key_r    <= sum_sat;
      mode_r   <= in_mode;
      mphase_r <= 1'b0;
    end else if (cmd.mod_step) begin
      mphase_r <= 1'b1;
      if (!mphase_r) begin
        quot_r <= recip_prod[PROD_W-1:RECIP_SH];
      end else begin
        rem_r <= rem_full[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      pos_r <= IW'(home_slot);
      cnt_r <= '0;
    end else if (cmd.probe_eval && !hit) begin
      pos_r <= pos_inc;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      mem_q   <= mem[pos_r];
      valid_q <= valid_r[pos_r];
    end
    if (cmd.probe_eval && hit && (mode_r == MODE_INSERT)) begin
      mem[pos_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.probe_eval && hit && (mode_r == MODE_INSERT)) begin
      valid_r[pos_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_eval) begin
      priority if (hit) begin
        res_slot_r <= SLOT_W'(pos_r);
        if (mode_r == MODE_INSERT) begin
          res_status_r <= ST_INSERTED;
          res_probes_r <= '0;
        end else begin
          res_status_r <= ST_FOUND;
          res_probes_r <= PROBE_W'(cnt_r) + 1'b1;
        end
      end else if (last_probe) begin
        res_slot_r <= '0;
        if (mode_r == MODE_INSERT) begin
          res_status_r <= ST_FULL;
          res_probes_r <= '0;
        end else begin
          res_status_r <= ST_NOT_FOUND;
          res_probes_r <= PROBE_W'(SLOTS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_probes_r <= res_probes_r;
      out_key_r    <= key_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_probes = out_probes_r;
  assign out_key    = out_key_r;

endmodule

/* design/linear_probe_hash_table_top.sv */
// Top level of the linear probing hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_dp.
//
// Characters that are not last are taken while idle and produce no result. A
// last character stalls the input while the key is reduced modulo SLOTS by a
// reciprocal multiplication (quotient estimate, then remainder), the
// remainder is brought below SLOTS to set the home slot, each probed slot is
// read from the key memory (registered read, then compare), and the result is
// handed to the output register. While an earlier result is still stalled in
// the output register the controller waits before the hand-off. The single
// read port of the key memory sets the probe pace. The key store is valid-bit
// cleared at reset, with no sweep.
module linear_probe_hash_table_top
  import lpht_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [PROBE_W-1:0] out_probes,
  output logic [KEY_W-1:0]   out_key
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_char (in_last_char),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  lpht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_mode      (in_mode),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_slot     (out_slot),
    .out_probes   (out_probes),
    .out_key      (out_key)
  );

endmodule

/* design/lpht_checker.sv */
// Port-level checker of the hash table top level, attached by bind.
// Depends on lpht_pkg and linear_probe_hash_table_top_defines.svh.
`include "linear_probe_hash_table_top_defines.svh"

module lpht_checker
  import lpht_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [SLOT_W-1:0]  out_slot,
  input logic [PROBE_W-1:0] out_probes,
  input logic [KEY_W-1:0]   out_key
);

  localparam logic [PROBE_W-1:0] SLOTS_P = PROBE_W'(SLOTS);
  localparam logic [SLOT_W:0]    SLOTS_S = (SLOT_W + 1)'(SLOTS);

  `LPHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_slot) && $stable(out_probes) && $stable(out_key), "stalled result item changed")
  `LPHT_ASSERT_NOW(a_insert_ok, out_valid && (out_status == ST_INSERTED), (out_probes == '0) && ({1'b0, out_slot} < SLOTS_S), "inserted item has bad slot or probe count")
  `LPHT_ASSERT_NOW(a_full, out_valid && (out_status == ST_FULL), (out_slot == '0) && (out_probes == '0), "table full item has nonzero slot or probes")
  `LPHT_ASSERT_NOW(a_found, out_valid && (out_status == ST_FOUND), (out_probes != '0) && (out_probes <= SLOTS_P) && ({1'b0, out_slot} < SLOTS_S), "found item has bad slot or probe count")
  `LPHT_ASSERT_NOW(a_not_found, out_valid && (out_status == ST_NOT_FOUND), (out_slot == '0) && (out_probes == SLOTS_P), "not found item has bad slot or probe count")

endmodule

bind linear_probe_hash_table_top lpht_checker #(
  .SLOTS (SLOTS)
) u_lpht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_slot   (out_slot),
  .out_probes (out_probes),
  .out_key    (out_key)
);
